// ===== hw/rtl/fks_pkg.sv =====
// Shared constants and control types for the keyed store.
package fks_pkg;

  // Fixed field widths at the channel ports
  localparam int unsigned IN_KEY_W   = 32;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  // Default table geometry
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Request modes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_STORE  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch request, rewind scan
    logic scan;    // issue entry reads
    logic commit;  // update table, load result register
  } fks_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // all occupied entries compared
    logic out_busy;   // result register full and not draining
  } fks_sts_t;

endpackage

// ===== hw/rtl/fks_if.sv =====
// Request and result channel interfaces.
interface fks_in_if;
  import fks_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [IN_KEY_W-1:0]  key;
  logic [IN_DATA_W-1:0] data_in;

  modport source (output valid, mode, key, data_in, input ready);
  modport sink   (input valid, mode, key, data_in, output ready);
endinterface

interface fks_out_if;
  import fks_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [OUT_DATA_W-1:0] data_out;
  logic                  evicted;

  modport source (output valid, hit, data_out, evicted, input ready);
  modport sink   (input valid, hit, data_out, evicted, output ready);
endinterface

// ===== hw/rtl/fifo_replacement_keyed_store.sv =====
// Top level of the fully associative keyed store with FIFO replacement.
// Each request scans every occupied slot before its result is loaded into the output register.
// A new request is taken only once the previous one has committed; the single
//   read port of the key/value memories scans one occupied slot per cycle.
// The next request is taken while a finished result waits in the output register.
// Reset (rst_n low, synchronous): table empty, oldest pointer zero, no result pending.
module fifo_replacement_keyed_store #(
  parameter int unsigned CAPACITY   = fks_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = fks_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = fks_pkg::VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fks_in_if.sink    in_ch,
  fks_out_if.source out_ch
);
  import fks_pkg::*;

  // Command/status bundle between sequencer and datapath
  fks_cmd_t cmd;
  fks_sts_t sts;

  // Sequencer: idle (ready) -> scan all occupied slots -> commit update and result.
  // Commit stalls only while the previous result has not been transferred.
  fks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: scan reads slots oldest-first with registered memory reads,
  // compares keys in the cycle after each read, then on a store overwrites in
  // place, appends at the tail, or replaces the oldest entry when the table is full.
  fks_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .req_mode    (in_ch.mode),
    .req_key     (in_ch.key),
    .req_data    (in_ch.data_in),
    .res_valid   (out_ch.valid),
    .res_ready   (out_ch.ready),
    .res_hit     (out_ch.hit),
    .res_data    (out_ch.data_out),
    .res_evicted (out_ch.evicted)
  );

endmodule

// ===== hw/rtl/fks_ctrl.sv =====
// Sequencing state machine: accept, scan, commit.
module fks_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fks_pkg::fks_sts_t  sts,
  output fks_pkg::fks_cmd_t  cmd
);
  import fks_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.start  = (state_r == S_IDLE) && in_valid;
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && !sts.out_busy;

endmodule

// ===== hw/rtl/fks_dp.sv =====
// Table memories, scan pointer, match capture, FIFO pointers and result register.
module fks_dp #(
  parameter int unsigned CAPACITY   = fks_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = fks_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = fks_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fks_pkg::fks_cmd_t                 cmd,
  output fks_pkg::fks_sts_t                 sts,
  input  logic                              req_mode,
  input  logic [fks_pkg::IN_KEY_W-1:0]      req_key,
  input  logic [fks_pkg::IN_DATA_W-1:0]     req_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic                              res_hit,
  output logic [fks_pkg::OUT_DATA_W-1:0]    res_data,
  output logic                              res_evicted
);
  import fks_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
    return (a == LAST_IDX) ? '0 : a + 1'b1;
  endfunction

  // Table storage, reset undefined; only reads of occupied slots are compared
  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [KEY_BITS-1:0]   key_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;

  // Latched request
  logic                  mode_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] data_r;

  // Scan and match
  logic [IDX_W-1:0]      scan_addr_r;
  logic [CNT_W-1:0]      scan_cnt_r;
  logic                  rd_valid_r;
  logic [IDX_W-1:0]      rd_addr_r;
  logic                  found_r;
  logic [IDX_W-1:0]      found_slot_r;
  logic [VALUE_BITS-1:0] found_val_r;

  // FIFO bookkeeping
  logic [IDX_W-1:0]      oldest_r;
  logic [CNT_W-1:0]      occ_r;

  // Result register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_evicted_r;

  logic             issue;
  logic             full;
  logic             is_store;
  logic             key_we;
  logic             val_we;
  logic [IDX_W-1:0] val_waddr;

  assign issue     = cmd.scan && (scan_cnt_r < occ_r);
  assign full      = (occ_r == FULL_CNT);
  assign is_store  = (mode_r == MODE_STORE);
  assign key_we    = cmd.commit && is_store && !found_r;
  assign val_we    = cmd.commit && is_store;
  // after a full scan the pointer sits on the tail, which is the oldest slot when full
  assign val_waddr = found_r ? found_slot_r : scan_addr_r;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[scan_addr_r] <= key_r;
    if (val_we) val_mem[val_waddr]   <= data_r;
    key_rd_r <= key_mem[scan_addr_r];
    val_rd_r <= val_mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= req_mode;
      key_r  <= KEY_BITS'(req_key);
      data_r <= VALUE_BITS'(req_data);
    end
    if (rd_valid_r && !found_r && (key_rd_r == key_r)) begin
      found_slot_r <= rd_addr_r;
      found_val_r  <= val_rd_r;
    end
    if (issue) rd_addr_r <= scan_addr_r;
    if (cmd.commit) begin
      out_hit_r     <= found_r;
      out_data_r    <= (!is_store && found_r) ? OUT_DATA_W'(found_val_r) : '0;
      out_evicted_r <= is_store && !found_r && full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      scan_cnt_r  <= '0;
      rd_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      oldest_r    <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= issue;
      if (cmd.start) begin
        scan_addr_r <= oldest_r;
        scan_cnt_r  <= '0;
        found_r     <= 1'b0;
      end else if (issue) begin
        scan_addr_r <= wrap_inc(scan_addr_r);
        scan_cnt_r  <= scan_cnt_r + 1'b1;
      end
      if (rd_valid_r && (key_rd_r == key_r)) found_r <= 1'b1;
      if (key_we) begin
        if (full) oldest_r <= wrap_inc(oldest_r);
        else      occ_r    <= occ_r + 1'b1;
      end
      if (cmd.commit)     out_valid_r <= 1'b1;
      else if (res_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.scan_done = (scan_cnt_r == occ_r) && !rd_valid_r;
  assign sts.out_busy  = out_valid_r && !res_ready;

  assign res_valid   = out_valid_r;
  assign res_hit     = out_hit_r;
  assign res_data    = out_data_r;
  assign res_evicted = out_evicted_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT) else $error("occupancy above capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_cnt_r <= occ_r) else $error("scan ran past occupancy");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (key_we && full) |=> (occ_r == FULL_CNT)) else $error("eviction left table short");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evicted_r |-> !out_hit_r) else $error("eviction on a hit");

  a_data_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> (out_data_r == '0)) else $error("data on a miss");

endmodule

// ===== bench/tb_fifo_replacement_keyed_store.sv =====
// Self-checking testbench for the FIFO-replacement keyed store: directed and random traffic.
`timescale 1ns / 1ps

typedef struct packed {
  logic                              hit;
  logic [fks_pkg::OUT_DATA_W-1:0]    data_out;
  logic                              evicted;
} kv_result_t;

// Shadow copy of the table plus the queue of results still owed by the block.
class store_scoreboard;
  logic [fks_pkg::KEY_BITS_DEF-1:0]   slot_key [fks_pkg::CAPACITY_DEF];
  logic [fks_pkg::VALUE_BITS_DEF-1:0] slot_val [fks_pkg::CAPACITY_DEF];
  int unsigned head;          // slot of the oldest entry
  int unsigned fill;          // occupied slots
  kv_result_t  awaited[$];
  int unsigned mismatches;
  int unsigned results_seen;

  function new();
    head = 0;
    fill = 0;
    mismatches = 0;
    results_seen = 0;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  // Apply one accepted request to the shadow table and queue its result.
  function void note_request(input logic mode, input logic [fks_pkg::IN_KEY_W-1:0] key,
                             input logic [fks_pkg::IN_DATA_W-1:0] value);
    kv_result_t  r;
    int unsigned at;
    int unsigned s;
    bit          found;
    found = 1'b0;
    at = 0;
    // search only the occupied slots, oldest first
    for (int unsigned i = 0; i < fill; i++) begin
      s = (head + i) % fks_pkg::CAPACITY_DEF;
      if (!found && slot_key[s] == key) begin
        found = 1'b1;
        at = s;
      end
    end
    r.hit = found;
    r.data_out = '0;
    r.evicted = 1'b0;
    if (mode == fks_pkg::MODE_LOOKUP) begin
      if (found) r.data_out = slot_val[at];
    end else if (found) begin
      slot_val[at] = value;
    end else if (fill == fks_pkg::CAPACITY_DEF) begin
      slot_key[head] = key;
      slot_val[head] = value;
      head = (head + 1) % fks_pkg::CAPACITY_DEF;
      r.evicted = 1'b1;
    end else begin
      s = (head + fill) % fks_pkg::CAPACITY_DEF;
      slot_key[s] = key;
      slot_val[s] = value;
      fill++;
    end
    awaited.push_back(r);
  endfunction

  task report_mismatch(input string what);
    $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
    mismatches++;
  endtask

  task check_result(input logic hit, input logic [fks_pkg::OUT_DATA_W-1:0] data_out,
                    input logic evicted);
    kv_result_t want;
    results_seen++;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("unexpected result hit=%0b data_out=%h evicted=%0b",
                                hit, data_out, evicted));
    end else begin
      want = awaited.pop_front();
      if (hit !== want.hit)
        report_mismatch($sformatf("hit got %0b want %0b", hit, want.hit));
      if (data_out !== want.data_out)
        report_mismatch($sformatf("data_out got %h want %h", data_out, want.data_out));
      if (evicted !== want.evicted)
        report_mismatch($sformatf("evicted got %0b want %0b", evicted, want.evicted));
    end
  endtask
endclass

module tb_fifo_replacement_keyed_store;
  import fks_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned KEY_POOL     = 48;   // keys that random traffic draws from
  localparam int unsigned DRAIN_CYCLES = 24;   // full-table scan latency plus margin

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Request side: driven through plain variables so every pin is known from time zero.
  logic                 req_valid = 1'b0;
  logic                 req_mode  = MODE_LOOKUP;
  logic [IN_KEY_W-1:0]  req_key   = '0;
  logic [IN_DATA_W-1:0] req_data  = '0;
  logic                 res_ready = 1'b0;

  // Receiver stall pattern state
  int unsigned stall_style = 0;
  int unsigned stall_span  = 0;
  int unsigned stall_tick  = 0;

  logic [IN_KEY_W-1:0] key_pool [KEY_POOL];

  store_scoreboard board;

  fks_in_if  in_ch ();
  fks_out_if out_ch ();

  assign in_ch.valid   = req_valid;
  assign in_ch.mode    = req_mode;
  assign in_ch.key     = req_key;
  assign in_ch.data_in = req_data;
  assign out_ch.ready  = res_ready;

  fifo_replacement_keyed_store DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  // Hard stop: a run still going at this time fails.
  initial begin
    #1_000_000;
    $display("tb_fifo_replacement_keyed_store: FAIL");
    $finish;
  end

  // Result side: check every transfer, then pick next cycle's ready.
  // A style is drawn at random whenever a span runs out: always ready, coin flip,
  // a fixed repeating pattern, and mostly-stalled with rare ready pulses.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.hit, out_ch.data_out, out_ch.evicted);

    if (stall_span == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_span  <= $urandom_range(20, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    stall_tick <= stall_tick + 1;

    case (stall_style)
      0: begin
        res_ready <= 1'b1;
      end
      1: begin
        res_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        res_ready <= (stall_tick % 7) inside {0, 3, 4};
      end
      default: begin
        res_ready <= ($urandom_range(0, 9) == 0);
      end
    endcase
  end

  // Present one request and hold it until the transfer. Called on a clock edge;
  // returns on the edge of the transfer, so a follow-up call keeps valid high.
  task automatic push_request(input logic mode, input logic [IN_KEY_W-1:0] key,
                              input logic [IN_DATA_W-1:0] value);
    req_valid <= 1'b1;
    req_mode  <= mode;
    req_key   <= key;
    req_data  <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(mode, key, value);
  endtask

  // Drop valid and wait until every owed result has been taken.
  task automatic hold_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Edge cases: empty-table misses, all-zero/all-one keys and values, overwrite in
  // place, fill to capacity, eviction of the oldest, and overwrite on a full table.
  task automatic run_directed();
    push_request(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);   // miss on empty table
    push_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // data_in ignored on lookup
    push_request(MODE_STORE,  32'h0000_0000, 32'hFFFF_FFFF);
    push_request(MODE_STORE,  32'hFFFF_FFFF, 32'h0000_0000);
    push_request(MODE_LOOKUP, 32'h0000_0000, 32'hA5A5_A5A5);
    push_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    push_request(MODE_STORE,  32'h0000_0000, 32'h1234_5678);   // overwrite in place
    push_request(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    // 14 more keys fill the table
    for (int unsigned i = 1; i <= CAPACITY_DEF - 2; i++)
      push_request(MODE_STORE, i, 32'hC000_0000 | i);
    push_request(MODE_STORE,  32'h0000_0100, 32'h5A5A_5A5A);   // full: key 0 goes out
    push_request(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);   // evicted key misses
    push_request(MODE_STORE,  32'hFFFF_FFFF, 32'h8000_0001);   // full, present: no eviction
    push_request(MODE_LOOKUP, 32'h0000_0100, 32'h0000_0000);
    push_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Random traffic over a shifting pool of keys. Pool size changes every 100
  // requests: small pools give mostly overwrites and hits, large ones churn evictions.
  task automatic run_random();
    int unsigned         burst_left;
    int unsigned         pool_used;
    logic                mode;
    logic [IN_KEY_W-1:0] key;
    logic [IN_DATA_W-1:0] value;
    for (int unsigned i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom();
    burst_left = $urandom_range(1, 16);
    pool_used = 8;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) pool_used = $urandom_range(3, KEY_POOL);
      if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, KEY_POOL - 1)] = $urandom();

      mode = ($urandom_range(0, 99) < 45) ? MODE_STORE : MODE_LOOKUP;
      case ($urandom_range(0, 19))
        0:       key = $urandom();
        1:       key = '0;
        2:       key = '1;
        default: key = key_pool[$urandom_range(0, pool_used - 1)];
      endcase
      case ($urandom_range(0, 9))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom();
      endcase

      push_request(mode, key, value);

      if (n % 400 == 399) begin
        hold_until_drained();
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          req_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
        end
      end
    end
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    hold_until_drained();
    run_random();

    // all requests sent: drain, then wait DRAIN_CYCLES more for stray results
    req_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.pending()));

    if (board.mismatches == 0) begin
      $display("tb_fifo_replacement_keyed_store: PASS");
    end else begin
      $display("tb_fifo_replacement_keyed_store: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fks_pkg.sv
hw/rtl/fks_if.sv
hw/rtl/fks_ctrl.sv
hw/rtl/fks_dp.sv
hw/rtl/fifo_replacement_keyed_store.sv
bench/tb_fifo_replacement_keyed_store.sv
